// ===== rtl/resp_array_bulk_string_parser_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef RESP_ARRAY_BULK_STRING_PARSER_TOP_MACROS_SVH
`define RESP_ARRAY_BULK_STRING_PARSER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RABSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rabsp check failed");

// Next-cycle implication, off while reset is high.
`define RABSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rabsp check failed");

`endif

// ===== rtl/rabsp_pkg.sv =====
package rabsp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload;
      logic       last_of_run;
   } rsp_item_type;

   // Up to three results produced by one item, oldest in slot 0.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][2:0] kinds;
      logic [7:0]      data;
   } bundle_type;

   typedef enum logic [2:0] {
      PH_LINE    = 3'd0,
      PH_COUNT   = 3'd1,
      PH_LEN     = 3'd2,
      PH_REST    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DRAIN   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      NUM_LEAD   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_DONE   = 2'd2
   } num_stage_type;

   localparam logic [2:0] K_PAYLOAD  = 3'd0;
   localparam logic [2:0] K_ELEM_END = 3'd1;
   localparam logic [2:0] K_CMD_END  = 3'd2;
   localparam logic [2:0] K_ABORT    = 3'd3;
   localparam logic [2:0] K_WARN     = 3'd4;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [1:0] SKIP_BYTES = 2'd2;

endpackage

// ===== rtl/rabsp_parser.sv =====
module rabsp_parser #(
   parameter int LEN_BITS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rabsp_pkg::req_item_type req_item,
   input  logic                   load_ok,
   output logic                   bundle_load,
   output rabsp_pkg::bundle_type  bundle
);
   import rabsp_pkg::*;

   localparam logic [32:0] LEN_MAX = (33'd1 << LEN_BITS) - 33'd1;
   localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // parser state
   phase_type           phase_ff, phase_in, phase_step;
   logic [COUNT_BITS-1:0] elems_ff, elems_in, elems_step;
   logic [31:0]         acc_ff, acc_in, acc_step;
   logic                neg_ff, neg_in, neg_step;
   logic                hasdig_ff, hasdig_in, hasdig_step;
   num_stage_type       stage_ff, stage_in, stage_step;
   logic [LEN_BITS-1:0] pay_left_ff, pay_left_in, pay_left_step;
   logic [1:0]          skip_ff, skip_in, skip_step;
   logic                in_array_ff, in_array_in, in_array_step;

   // decoded events of the current item
   logic [7:0]  c;
   logic        is_lf, is_digit, is_ws, is_sign;
   logic [35:0] acc_x10;
   logic [31:0] acc_sat;
   logic        ev_other, ev_count_end, ev_len_end, ev_pay;
   logic        count_bad, len_bad, bulk_done, slot, slot_empty, abort_now, cnt_zero;
   logic [COUNT_BITS-1:0] cnt_clamped;
   logic [LEN_BITS-1:0]   len_clamped;

   assign bundle_load = in_valid_ff && load_ok;
   assign req_stall   = in_valid_ff && !load_ok;

   always_comb begin
      in_item_in = in_item_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (bundle_load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      c        = in_item_ff.data_byte;
      is_lf    = (c == CH_LF);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
                 (c == CH_CR);
      is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
      acc_x10  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {28'd0, c - CH_ZERO};
      acc_sat  = (|acc_x10[35:32]) ? 32'hFFFF_FFFF : acc_x10[31:0];

      cnt_clamped = ({1'b0, acc_ff} > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                              : acc_ff[COUNT_BITS-1:0];
      len_clamped = ({1'b0, acc_ff} > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0]
                                              : acc_ff[LEN_BITS-1:0];
      cnt_zero    = (acc_ff == 32'd0);

      ev_other     = is_lf && ((phase_ff == PH_LINE) || (phase_ff == PH_REST));
      ev_count_end = is_lf && (phase_ff == PH_COUNT);
      ev_len_end   = is_lf && (phase_ff == PH_LEN);
      ev_pay       = (phase_ff == PH_PAYLOAD) && (pay_left_ff != '0);
      count_bad    = !hasdig_ff;
      len_bad      = !hasdig_ff || (neg_ff && !cnt_zero);
      bulk_done    = (ev_len_end && !len_bad && cnt_zero) ||
                     (ev_pay && (pay_left_ff == LEN_BITS'(1)));
      slot         = in_array_ff && (ev_other || bulk_done);
      // slot count reaches zero (or was already zero) after this slot
      slot_empty   = slot && (elems_ff <= COUNT_BITS'(1));
      abort_now    = (ev_count_end && count_bad) || (ev_len_end && len_bad);
   end

   // next state, before the end-of-buffer reset
   always_comb begin
      phase_step    = phase_ff;
      elems_step    = elems_ff;
      acc_step      = acc_ff;
      neg_step      = neg_ff;
      hasdig_step   = hasdig_ff;
      stage_step    = stage_ff;
      pay_left_step = pay_left_ff;
      skip_step     = skip_ff;
      in_array_step = in_array_ff;

      unique case (phase_ff)
         PH_LINE: begin
            if (c == CH_DOLLAR || (c == CH_STAR && !in_array_ff)) begin
               acc_step    = '0;
               neg_step    = 1'b0;
               hasdig_step = 1'b0;
               stage_step  = NUM_LEAD;
               phase_step  = (c == CH_DOLLAR) ? PH_LEN : PH_COUNT;
            end else if (!is_lf) begin
               phase_step = PH_REST;
            end
         end
         PH_REST: begin
            if (is_lf) phase_step = PH_LINE;
         end
         PH_COUNT, PH_LEN: begin
            if (!is_lf) begin
               priority if (stage_ff == NUM_LEAD && is_ws) begin
               end else if (stage_ff == NUM_LEAD && is_sign) begin
                  neg_step   = (c == CH_MINUS);
                  stage_step = NUM_DIGITS;
               end else if ((stage_ff == NUM_LEAD || stage_ff == NUM_DIGITS) && is_digit) begin
                  acc_step    = acc_sat;
                  hasdig_step = 1'b1;
                  stage_step  = NUM_DIGITS;
               end else if (stage_ff == NUM_LEAD || stage_ff == NUM_DIGITS) begin
                  stage_step = NUM_DONE;
               end else begin
               end
            end else if (abort_now) begin
               phase_step = PH_DRAIN;
            end else if (phase_ff == PH_COUNT) begin
               phase_step = PH_LINE;
               if (!neg_ff && !cnt_zero) begin
                  elems_step    = cnt_clamped;
                  in_array_step = 1'b1;
               end
            end else begin
               phase_step    = PH_PAYLOAD;
               pay_left_step = len_clamped;
               skip_step     = SKIP_BYTES;
            end
         end
         PH_PAYLOAD: begin
            if (ev_pay) begin
               pay_left_step = pay_left_ff - LEN_BITS'(1);
            end else begin
               if (skip_ff != 2'd0) skip_step = skip_ff - 2'd1;
               if (skip_ff <= 2'd1) phase_step = PH_LINE;
            end
         end
         default: begin
         end
      endcase

      if (bulk_done) begin
         pay_left_step = '0;
         skip_step     = SKIP_BYTES;
      end
      if (slot) begin
         if (elems_ff != '0) elems_step = elems_ff - COUNT_BITS'(1);
         if (slot_empty) in_array_step = 1'b0;
      end
   end

   // results of the current item, in order
   always_comb begin
      logic [3:0][2:0] kd;
      logic [1:0]      n;
      logic            partial;
      kd = '0;
      n  = 2'd0;
      if (ev_pay && in_array_ff) begin
         kd[n] = K_PAYLOAD;  n = n + 2'd1;
      end
      if (ev_other && !in_array_ff) begin
         kd[n] = K_WARN;     n = n + 2'd1;
         kd[n] = K_CMD_END;  n = n + 2'd1;
      end
      if (ev_count_end && !count_bad && (neg_ff || cnt_zero)) begin
         kd[n] = K_CMD_END;  n = n + 2'd1;
      end
      if (bulk_done) begin
         kd[n] = in_array_ff ? K_ELEM_END : K_CMD_END;
         n = n + 2'd1;
      end
      if (slot_empty) begin
         kd[n] = K_CMD_END;  n = n + 2'd1;
      end
      if (abort_now) begin
         kd[n] = K_ABORT;    n = n + 2'd1;
      end
      partial = (phase_step == PH_COUNT) || (phase_step == PH_LEN) ||
                (phase_step == PH_REST) ||
                ((phase_step == PH_PAYLOAD) && (pay_left_step != '0)) || in_array_step;
      if (in_item_ff.buffer_end && partial && (phase_step != PH_DRAIN)) begin
         kd[n] = K_ABORT;    n = n + 2'd1;
      end
      bundle.count = n;
      bundle.kinds = kd[2:0];
      bundle.data  = c;
   end

   always_comb begin
      if (in_item_ff.buffer_end) begin
         phase_in    = PH_LINE;
         elems_in    = '0;
         acc_in      = '0;
         neg_in      = 1'b0;
         hasdig_in   = 1'b0;
         stage_in    = NUM_LEAD;
         pay_left_in = '0;
         skip_in     = 2'd0;
         in_array_in = 1'b0;
      end else begin
         phase_in    = phase_step;
         elems_in    = elems_step;
         acc_in      = acc_step;
         neg_in      = neg_step;
         hasdig_in   = hasdig_step;
         stage_in    = stage_step;
         pay_left_in = pay_left_step;
         skip_in     = skip_step;
         in_array_in = in_array_step;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_LINE;
         elems_ff    <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         hasdig_ff   <= 1'b0;
         stage_ff    <= NUM_LEAD;
         pay_left_ff <= '0;
         skip_ff     <= 2'd0;
         in_array_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (bundle_load) begin
            phase_ff    <= phase_in;
            elems_ff    <= elems_in;
            acc_ff      <= acc_in;
            neg_ff      <= neg_in;
            hasdig_ff   <= hasdig_in;
            stage_ff    <= stage_in;
            pay_left_ff <= pay_left_in;
            skip_ff     <= skip_in;
            in_array_ff <= in_array_in;
         end
      end
   end

endmodule

// ===== rtl/rabsp_rsp_queue.sv =====
module rabsp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   bundle_load,
   input  rabsp_pkg::bundle_type  bundle,
   output logic                   load_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rabsp_pkg::rsp_item_type rsp_item
);
   import rabsp_pkg::*;

   logic [1:0]      cnt_ff, cnt_in;
   logic [2:0][2:0] kinds_ff, kinds_in;
   logic [7:0]      data_ff, data_in;
   logic            pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   // free now, or the last pending result leaves this cycle
   assign load_ok   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall);

   assign rsp_item.kind        = kinds_ff[0];
   assign rsp_item.payload     = (kinds_ff[0] == K_PAYLOAD) ? data_ff : 8'd0;
   assign rsp_item.last_of_run = (cnt_ff == 2'd1);

   always_comb begin
      cnt_in   = cnt_ff;
      kinds_in = kinds_ff;
      data_in  = data_ff;
      if (bundle_load) begin
         cnt_in   = bundle.count;
         kinds_in = bundle.kinds;
         data_in  = bundle.data;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         kinds_in = {K_PAYLOAD, kinds_ff[2:1]};
      end
   end

   always_ff @(posedge clock) begin
      kinds_ff <= kinds_in;
      data_ff  <= data_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/resp_array_bulk_string_parser_top.sv =====
// Channel   Direction  Ports                          Payload
// request   in         req_valid, req_stall           req_item  (data_byte, buffer_end)
// response  out        rsp_valid, rsp_stall           rsp_item  (kind, payload, last_of_run)
//
// A byte is held in the input register, then its zero to three results leave the result
// register one per cycle while rsp_stall is low; a byte with a single result sustains one
// byte per cycle. A byte with several results holds the input until its last result leaves
// the single result port. An accepted byte reaches it via the input and result registers.
// Reset is synchronous and returns the parser to the start of a top-level line.
// Stall on the response side backs up into req_stall in the same cycle.
module resp_array_bulk_string_parser_top #(
   parameter int LEN_BITS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rabsp_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rabsp_pkg::rsp_item_type rsp_item
);
   import rabsp_pkg::*;

   logic       load_ok;
   logic       bundle_load;
   bundle_type bundle;

   rabsp_parser #(
      .LEN_BITS   (LEN_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .load_ok     (load_ok),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   rabsp_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .bundle_load (bundle_load),
      .bundle      (bundle),
      .load_ok     (load_ok),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== rtl/rabsp_checker.sv =====
`include "resp_array_bulk_string_parser_top_macros.svh"

module rabsp_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input rabsp_pkg::req_item_type req_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input rabsp_pkg::rsp_item_type rsp_item
);
   import rabsp_pkg::*;

   logic req_seen;
   logic rsp_held;
   logic rsp_abort;
   logic rsp_plain;
   assign req_seen  = req_valid && !req_stall && req_item.buffer_end;
   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_abort = rsp_valid && (rsp_item.kind == K_ABORT);
   assign rsp_plain = rsp_valid && (rsp_item.kind != K_PAYLOAD) && !req_seen;

   // a held result keeps its value
   `RABSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_item))
   // nothing is pending right after reset
   `RABSP_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
   // an abort always closes the results of its byte
   `RABSP_ASSERT_NOW(a_abort_last, clock, reset, rsp_abort, rsp_item.last_of_run)
   // only payload results carry a data byte
   `RABSP_ASSERT_NOW(a_payload_zero, clock, reset, rsp_plain, rsp_item.payload == 8'd0)

endmodule

bind resp_array_bulk_string_parser_top rabsp_checker u_checker (.*);
